>>> hdl/adaptive_threshold_quadrature_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef ADAPTIVE_THRESHOLD_QUADRATURE_DECODER_MACROS_SVH
`define ADAPTIVE_THRESHOLD_QUADRATURE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
`define ATQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ATQD_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ATQD_ASSERT(lbl, prop, msg)
`define ATQD_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

>>> hdl/atqd_pkg.sv
package atqd_pkg;

  localparam int unsigned SampleW = 10;

  localparam logic [SampleW-1:0] MinReset   = 10'd1023;
  localparam logic [SampleW-1:0] RangeReset = 10'd30;

  localparam logic signed [1:0] StepNone = 2'sb00;
  localparam logic signed [1:0] StepFwd  = 2'sb01;
  localparam logic signed [1:0] StepBack = 2'sb11;

  typedef enum logic [1:0] {
    Q_HIHI,
    Q_HILO,
    Q_LOLO,
    Q_LOHI
  } quad_state_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_TRACK,
    L_SUM,
    L_DIV,
    L_LEVEL,
    L_DONE
  } lane_state_e;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic               done;
    logic [SampleW-1:0] level;
  } lane_sts_t;

  // floor(x/3) for x < 1024 by reciprocal multiply
  function automatic logic [SampleW-1:0] div3(input logic [SampleW-1:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[20:11];
  endfunction

endpackage

>>> hdl/atqd_lane.sv
module atqd_lane
  import atqd_pkg::*;
#(
  parameter int unsigned RING_SIZE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctl_t          ctl_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [SampleW-1:0] range_limit_i,
  output lane_sts_t          sts_o
);

  localparam int unsigned AW   = $clog2(RING_SIZE);
  localparam int unsigned NW   = $clog2(RING_SIZE + 1);
  localparam int unsigned SUMW = SampleW + NW;
  localparam int unsigned DCW  = $clog2(SUMW + 1);

  lane_state_e st_q, st_d;

  logic [SampleW-1:0] mn_q, mx_q, level_q;
  logic               seen_lo_q, seen_hi_q;
  logic [AW-1:0]      vslot_q, pslot_q;
  logic               vwrap_q, pwrap_q;
  logic [NW-1:0]      cnt_q;
  logic               vflag_q, pflag_q;
  logic [SUMW-1:0]    vacc_q, pacc_q, vdv_q, pdv_q;
  logic [NW-1:0]      vrem_q, prem_q;
  logic [DCW-1:0]     div_cnt_q;

  logic [SampleW-1:0] vmem [RING_SIZE];
  logic [SampleW-1:0] pmem [RING_SIZE];
  logic [SampleW-1:0] vrd_q, prd_q;

  logic [NW-1:0] nv, np;
  assign nv = vwrap_q ? NW'(RING_SIZE) : NW'(vslot_q);
  assign np = pwrap_q ? NW'(RING_SIZE) : NW'(pslot_q);

  // tracking step
  logic [SampleW-1:0] mn1, mx1, span, cut, mid;
  logic               armed, rec_pk, rec_vl;
  always_comb begin
    mn1    = (sample_i < mn_q) ? sample_i : mn_q;
    mx1    = (sample_i > mx_q) ? sample_i : mx_q;
    span   = mx1 - mn1;
    cut    = mn1 + div3(span);
    mid    = mn1 + (span >> 1);
    armed  = span >= range_limit_i;
    rec_pk = armed && (sample_i < cut) && seen_hi_q;
    rec_vl = armed && (sample_i > cut) && seen_lo_q;
  end

  // one restoring divide step per ring
  logic [NW:0] vrem_n, prem_n;
  logic        vbit, pbit;
  always_comb begin
    vrem_n = {vrem_q, vdv_q[SUMW-1]};
    prem_n = {prem_q, pdv_q[SUMW-1]};
    vbit   = vrem_n >= {1'b0, nv};
    pbit   = prem_n >= {1'b0, np};
  end

  // threshold from the two means
  logic [SampleW-1:0]   lo, hi, mag, q3, lvl;
  logic signed [SampleW:0] diff;
  always_comb begin
    lo   = (nv == '0) ? mn_q : vdv_q[SampleW-1:0];
    hi   = (np == '0) ? mx_q : pdv_q[SampleW-1:0];
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    mag  = diff[SampleW] ? SampleW'(-diff) : diff[SampleW-1:0];
    q3   = div3(mag);
    lvl  = diff[SampleW] ? (lo - q3) : (lo + q3);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      L_IDLE:  if (ctl_i.start) st_d = (vwrap_q && pwrap_q) ? L_DONE : L_TRACK;
      L_TRACK: st_d = L_SUM;
      L_SUM:   if (cnt_q == NW'(RING_SIZE)) st_d = L_DIV;
      L_DIV:   if (div_cnt_q == DCW'(1)) st_d = L_LEVEL;
      L_LEVEL: st_d = L_DONE;
      L_DONE:  if (ctl_i.ack) st_d = L_IDLE;
      default: st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= L_IDLE;
      mn_q      <= MinReset;
      mx_q      <= '0;
      seen_lo_q <= 1'b0;
      seen_hi_q <= 1'b0;
      vslot_q   <= '0;
      pslot_q   <= '0;
      vwrap_q   <= 1'b0;
      pwrap_q   <= 1'b0;
      level_q   <= '0;
      cnt_q     <= '0;
      vflag_q   <= 1'b0;
      pflag_q   <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        L_TRACK: begin
          cnt_q   <= '0;
          vflag_q <= 1'b0;
          pflag_q <= 1'b0;
          if (rec_pk || rec_vl) begin
            mn_q      <= mid;
            mx_q      <= mid;
            seen_lo_q <= 1'b0;
            seen_hi_q <= 1'b0;
          end else begin
            mn_q <= mn1;
            mx_q <= mx1;
            if (armed && sample_i < cut) seen_lo_q <= 1'b1;
            if (armed && sample_i > cut) seen_hi_q <= 1'b1;
          end
          if (rec_pk) begin
            if (pslot_q == AW'(RING_SIZE - 1)) begin
              pslot_q <= '0;
              pwrap_q <= 1'b1;
            end else begin
              pslot_q <= pslot_q + 1'b1;
            end
          end
          if (rec_vl) begin
            if (vslot_q == AW'(RING_SIZE - 1)) begin
              vslot_q <= '0;
              vwrap_q <= 1'b1;
            end else begin
              vslot_q <= vslot_q + 1'b1;
            end
          end
        end
        L_SUM: begin
          if (cnt_q != NW'(RING_SIZE)) cnt_q <= cnt_q + 1'b1;
          vflag_q   <= (cnt_q != NW'(RING_SIZE)) && (cnt_q < nv);
          pflag_q   <= (cnt_q != NW'(RING_SIZE)) && (cnt_q < np);
          div_cnt_q <= DCW'(SUMW);
        end
        L_DIV: div_cnt_q <= div_cnt_q - 1'b1;
        L_LEVEL: level_q <= lvl;
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (st_q == L_TRACK) begin
      vacc_q <= '0;
      pacc_q <= '0;
      if (rec_pk) pmem[pslot_q] <= mx1;
      if (rec_vl) vmem[vslot_q] <= mn1;
    end
    if (st_q == L_SUM) begin
      vrd_q <= vmem[cnt_q[AW-1:0]];
      prd_q <= pmem[cnt_q[AW-1:0]];
      if (vflag_q) vacc_q <= vacc_q + SUMW'(vrd_q);
      if (pflag_q) pacc_q <= pacc_q + SUMW'(prd_q);
      vrem_q <= '0;
      prem_q <= '0;
      vdv_q  <= (vflag_q) ? vacc_q + SUMW'(vrd_q) : vacc_q;
      pdv_q  <= (pflag_q) ? pacc_q + SUMW'(prd_q) : pacc_q;
    end
    if (st_q == L_DIV) begin
      vrem_q <= vbit ? NW'(vrem_n - {1'b0, nv}) : vrem_n[NW-1:0];
      prem_q <= pbit ? NW'(prem_n - {1'b0, np}) : prem_n[NW-1:0];
      vdv_q  <= {vdv_q[SUMW-2:0], vbit};
      pdv_q  <= {pdv_q[SUMW-2:0], pbit};
    end
  end

  assign sts_o.done  = (st_q == L_DONE);
  assign sts_o.level = level_q;

endmodule

>>> hdl/atqd_quad.sv
module atqd_quad
  import atqd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic              ha_i,
  input  logic              hb_i,
  output logic signed [1:0] step_o
);

  quad_state_e st_q, st_d;
  logic lohi_q, lohi_d, hilo_q, hilo_d;

  always_comb begin
    st_d   = st_q;
    lohi_d = lohi_q;
    hilo_d = hilo_q;
    step_o = StepNone;
    case (st_q)
      Q_HIHI: begin
        if (!ha_i && hb_i) begin
          st_d = Q_LOHI;
          if (hilo_q) begin
            step_o = StepFwd;
            hilo_d = 1'b0;
          end
        end else if (ha_i && !hb_i) begin
          st_d = Q_HILO;
          if (lohi_q) begin
            step_o = StepBack;
            lohi_d = 1'b0;
          end
        end
      end
      Q_LOLO: begin
        if (ha_i && !hb_i) begin
          st_d = Q_HILO;
          if (lohi_q) begin
            step_o = StepFwd;
            lohi_d = 1'b0;
          end
        end else if (!ha_i && hb_i) begin
          st_d = Q_LOHI;
          if (hilo_q) begin
            step_o = StepBack;
            hilo_d = 1'b0;
          end
        end
      end
      Q_HILO: begin
        if (ha_i == hb_i) begin
          st_d   = ha_i ? Q_HIHI : Q_LOLO;
          hilo_d = 1'b1;
          lohi_d = 1'b0;
        end
      end
      Q_LOHI: begin
        if (ha_i == hb_i) begin
          st_d   = ha_i ? Q_HIHI : Q_LOLO;
          lohi_d = 1'b1;
          hilo_d = 1'b0;
        end
      end
      default: st_d = Q_HIHI;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= Q_HIHI;
      lohi_q <= 1'b0;
      hilo_q <= 1'b0;
    end else if (go_i) begin
      st_q   <= st_d;
      lohi_q <= lohi_d;
      hilo_q <= hilo_d;
    end
  end

endmodule

>>> hdl/adaptive_threshold_quadrature_decoder.sv
// One transaction in, one step out; one transaction in flight at a time.
// SUMW = 10 + clog2(RING_SIZE+1). Steps: a tracking step, summing of both rings, a SUMW-step
// divide per ring and a level step. The next transaction is accepted from the cycle after the
// step is registered. With both channels frozen (all rings wrapped), a transaction goes
// straight to done. Output stalls delay the step.
// Async active-low reset: range_limit 30, extremes 1023/0, levels 0, state HIHI; rings unreset.
`include "adaptive_threshold_quadrature_decoder_macros.svh"

module adaptive_threshold_quadrature_decoder
  import atqd_pkg::*;
#(
  parameter int unsigned RING_SIZE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SampleW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] sample_a_i,
  input  logic [SampleW-1:0] sample_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [1:0]  step_o
);

  logic [SampleW-1:0] range_q, a_q, b_q;
  logic               busy_q, out_vld_q;
  logic signed [1:0]  step_q, step_n;
  lane_ctl_t          ctl;
  lane_sts_t          sts_a, sts_b;
  logic               accept, load;

  assign accept = in_valid_i && !busy_q;
  assign load   = sts_a.done && sts_b.done && (!out_vld_q || !out_stall_i);

  assign ctl.start = accept;
  assign ctl.ack   = load;

  atqd_lane #(.RING_SIZE(RING_SIZE)) u_lane_a (
    .clk_i, .rst_ni, .ctl_i(ctl), .sample_i(a_q), .range_limit_i(range_q), .sts_o(sts_a)
  );

  atqd_lane #(.RING_SIZE(RING_SIZE)) u_lane_b (
    .clk_i, .rst_ni, .ctl_i(ctl), .sample_i(b_q), .range_limit_i(range_q), .sts_o(sts_b)
  );

  atqd_quad u_quad (
    .clk_i,
    .rst_ni,
    .go_i  (load),
    .ha_i  (a_q >= sts_a.level),
    .hb_i  (b_q >= sts_b.level),
    .step_o(step_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q   <= RangeReset;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) range_q <= cfg_wdata_i;
      if (accept) busy_q <= 1'b1;
      else if (load) busy_q <= 1'b0;
      if (load) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= sample_a_i;
      b_q <= sample_b_i;
    end
    if (load) step_q <= step_n;
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_vld_q;
  assign step_o      = step_q;

  `ATQD_ASSERT(a_accept_busy, in_valid_i && !in_stall_o |=> in_stall_o, "no busy after accept")
  `ATQD_ASSERT(a_step_code, out_valid_o |-> step_o != 2'sb10, "illegal step code")
  `ATQD_ASSERT_ANY(a_idle_lanes, !busy_q |-> !sts_a.done && !sts_b.done, "lane done while idle")

endmodule
